@@ design/folc_pkg.sv @@
// Package: shared constants, types and codes of the flow owner LRU cache.
package folc_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int ADDR_W        = 64;
  localparam int PORT_W        = 16;
  localparam int PROTO_W       = 8;
  localparam int ID_W          = 32;
  localparam int KEY_W         = 4 * ADDR_W + 2 * PORT_W + PROTO_W + 1;
  localparam int MAX_ENTRIES_W = 7;
  localparam int COUNT_W_DEF   = 7;
  localparam int CFG_DATA_W    = 32;
  localparam int PADDR_W       = 3;

  localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 7'd64;
  localparam logic signed [ID_W-1:0]   NOT_FOUND_ID    = -32'sd2;

  // action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ADD    = 1'b1;

  // register index (paddr word select)
  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SWEEP,
    ST_FINISH
  } folc_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_DECIDE,
    OP_SWEEP,
    OP_FINISH
  } folc_op_t;

  typedef struct packed {
    folc_op_t op;
  } folc_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_sweep;
    logic out_free;
  } folc_stat_t;

endpackage

@@ design/folc_if.sv @@
// Interfaces: request and response channels of the flow owner LRU cache.
interface flow_req_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    action;
  logic [folc_pkg::ADDR_W-1:0]             src_addr_high;
  logic [folc_pkg::ADDR_W-1:0]             src_addr_low;
  logic [folc_pkg::ADDR_W-1:0]             dst_addr_high;
  logic [folc_pkg::ADDR_W-1:0]             dst_addr_low;
  logic [folc_pkg::PORT_W-1:0]             src_port;
  logic [folc_pkg::PORT_W-1:0]             dst_port;
  logic [folc_pkg::PROTO_W-1:0]            protocol;
  logic                                    ip_version;
  logic signed [folc_pkg::ID_W-1:0]        owner_id;

  modport source (output valid, action, src_addr_high, src_addr_low, dst_addr_high,
                  dst_addr_low, src_port, dst_port, protocol, ip_version, owner_id,
                  input ready);
  modport sink (input valid, action, src_addr_high, src_addr_low, dst_addr_high,
                dst_addr_low, src_port, dst_port, protocol, ip_version, owner_id,
                output ready);
endinterface

interface flow_rsp_if #(
  parameter int CNT_W = folc_pkg::COUNT_W_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [folc_pkg::ID_W-1:0] found_id;
  logic [CNT_W-1:0]                 entry_count;
  logic                             evicted;

  modport source (output valid, hit, found_id, entry_count, evicted, input ready);
  modport sink (input valid, hit, found_id, entry_count, evicted, output ready);
endinterface

@@ design/folc_ctrl.sv @@
// Controller: sequences clear, scan, decide, sweep and result hand-off.
module folc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  folc_pkg::folc_stat_t stat,
  output logic                 req_ready,
  output folc_pkg::folc_cmd_t  cmd
);

  folc_pkg::folc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= folc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = folc_pkg::OP_NONE;
    req_ready  = 1'b0;
    case (state)
      folc_pkg::ST_CLEAR: begin
        cmd.op = folc_pkg::OP_CLEAR;
        if (stat.idx_last) state_next = folc_pkg::ST_IDLE;
      end
      folc_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = folc_pkg::OP_LOAD;
          state_next = folc_pkg::ST_SCAN;
        end
      end
      folc_pkg::ST_SCAN: begin
        cmd.op = folc_pkg::OP_SCAN;
        if (stat.idx_last) state_next = folc_pkg::ST_SCAN_END;
      end
      folc_pkg::ST_SCAN_END: begin
        state_next = folc_pkg::ST_DECIDE;
      end
      folc_pkg::ST_DECIDE: begin
        cmd.op     = folc_pkg::OP_DECIDE;
        state_next = stat.need_sweep ? folc_pkg::ST_SWEEP : folc_pkg::ST_FINISH;
      end
      folc_pkg::ST_SWEEP: begin
        cmd.op = folc_pkg::OP_SWEEP;
        if (stat.idx_last) state_next = folc_pkg::ST_FINISH;
      end
      folc_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.op     = folc_pkg::OP_FINISH;
          state_next = folc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = folc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

@@ design/folc_dp.sv @@
// Datapath: entry memories, scan and sweep logic, count and result register.
module folc_dp #(
  parameter int CAPACITY = folc_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  folc_pkg::folc_cmd_t                    cmd,
  output folc_pkg::folc_stat_t                   stat,
  input  logic                                   in_action,
  input  logic [folc_pkg::KEY_W-1:0]             in_key,
  input  logic signed [folc_pkg::ID_W-1:0]       in_owner_id,
  input  logic [folc_pkg::MAX_ENTRIES_W-1:0]     max_entries,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic signed [folc_pkg::ID_W-1:0]       out_found_id,
  output logic [CNT_W-1:0]                       out_entry_count,
  output logic                                   out_evicted
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int RANK_W = IDX_W;
  localparam int META_W = 1 + RANK_W;
  localparam int LIM_W  = (CNT_W > folc_pkg::MAX_ENTRIES_W) ? CNT_W
                                                            : folc_pkg::MAX_ENTRIES_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [LIM_W-1:0] LIM_CAP  = LIM_W'(CAPACITY);

  // memories
  logic [folc_pkg::KEY_W-1:0] key_mem  [CAPACITY];
  logic [folc_pkg::ID_W-1:0]  id_mem   [CAPACITY];
  logic [META_W-1:0]          meta_mem [CAPACITY];

  logic [folc_pkg::KEY_W-1:0] key_rd;
  logic [folc_pkg::ID_W-1:0]  id_rd;
  logic [META_W-1:0]          meta_rd;

  // item and control registers
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           rd_idx;
  logic                       rd_scan;
  logic                       rd_sweep;
  logic                       act_q;
  logic [folc_pkg::KEY_W-1:0] key_q;
  logic [folc_pkg::ID_W-1:0]  id_q;
  logic [CNT_W-1:0]           count;

  // scan results
  logic                       hit_f;
  logic [IDX_W-1:0]           slot;
  logic [RANK_W-1:0]          hit_rank;
  logic [folc_pkg::ID_W-1:0]  hit_id;
  logic [IDX_W-1:0]           old_slot;
  logic                       free_f;
  logic [IDX_W-1:0]           free_slot;

  // decision
  logic                       ev;
  logic [IDX_W-1:0]           ins_slot;

  logic [LIM_W-1:0]           lim;
  logic [LIM_W-1:0]           count_ext;
  logic                       ev_c;
  logic [IDX_W-1:0]           ins_c;
  logic [CNT_W-1:0]           count_m1;
  logic [CNT_W-1:0]           count_next;

  logic                       mv;
  logic [RANK_W-1:0]          mk;
  logic                       wb_v;
  logic [RANK_W-1:0]          wb_k;

  logic                       meta_we;
  logic [IDX_W-1:0]           meta_wa;
  logic [META_W-1:0]          meta_wd;
  logic                       key_we;
  logic                       id_we;
  logic [IDX_W-1:0]           id_wa;

  assign mv       = meta_rd[META_W-1];
  assign mk       = meta_rd[RANK_W-1:0];
  assign count_m1 = count - CNT_W'(1);

  // limit: zero acts as one, values above capacity act as capacity
  always_comb begin
    if (max_entries == '0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(max_entries) > LIM_CAP) begin
      lim = LIM_CAP;
    end else begin
      lim = LIM_W'(max_entries);
    end
  end

  assign count_ext = LIM_W'(count);

  always_comb begin
    ev_c = 1'b0;
    if (act_q == folc_pkg::ACT_ADD) begin
      ev_c = hit_f ? (count_ext > lim) : (count_ext >= lim);
    end
    ins_c = (ev_c && (!free_f || old_slot < free_slot)) ? old_slot : free_slot;
  end

  assign count_next = count + CNT_W'(act_q == folc_pkg::ACT_ADD && !hit_f) - CNT_W'(ev);

  // rank update of one entry during the sweep
  always_comb begin
    wb_v = mv;
    wb_k = mk;
    if (hit_f) begin
      if (mv) begin
        if (rd_idx == slot)       wb_k = '0;
        else if (mk < hit_rank)   wb_k = mk + RANK_W'(1);
        if (ev && CNT_W'(wb_k) == count_m1) begin
          wb_v = 1'b0;
          wb_k = '0;
        end
      end
    end else begin
      if (rd_idx == ins_slot) begin
        wb_v = 1'b1;
        wb_k = '0;
      end else if (mv) begin
        if (ev && CNT_W'(mk) == count_m1) begin
          wb_v = 1'b0;
          wb_k = '0;
        end else begin
          wb_k = mk + RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = rd_idx;
    meta_wd = {wb_v, wb_k};
    if (cmd.op == folc_pkg::OP_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = idx;
      meta_wd = '0;
    end else if (rd_sweep) begin
      meta_we = 1'b1;
    end
    key_we = (cmd.op == folc_pkg::OP_DECIDE) && act_q == folc_pkg::ACT_ADD && !hit_f;
    id_we  = (cmd.op == folc_pkg::OP_DECIDE) && act_q == folc_pkg::ACT_ADD;
    id_wa  = hit_f ? slot : ins_c;
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (key_we)  key_mem[ins_c]    <= key_q;
    if (id_we)   id_mem[id_wa]     <= id_q;
    meta_rd <= meta_mem[idx];
    key_rd  <= key_mem[idx];
    id_rd   <= id_mem[idx];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_scan   <= 1'b0;
      rd_sweep  <= 1'b0;
      count     <= '0;
      hit_f     <= 1'b0;
      free_f    <= 1'b0;
      ev        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_scan  <= (cmd.op == folc_pkg::OP_SCAN);
      rd_sweep <= (cmd.op == folc_pkg::OP_SWEEP);
      case (cmd.op)
        folc_pkg::OP_CLEAR, folc_pkg::OP_SCAN, folc_pkg::OP_SWEEP: begin
          idx <= (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
        end
        folc_pkg::OP_LOAD: begin
          idx    <= '0;
          hit_f  <= 1'b0;
          free_f <= 1'b0;
        end
        folc_pkg::OP_DECIDE: begin
          idx <= '0;
          ev  <= ev_c;
        end
        folc_pkg::OP_FINISH: begin
          count <= count_next;
        end
        default: begin
        end
      endcase
      if (rd_scan) begin
        if (mv && key_rd == key_q && !hit_f) hit_f <= 1'b1;
        if (!mv && !free_f) free_f <= 1'b1;
      end
      if (cmd.op == folc_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (cmd.op == folc_pkg::OP_LOAD) begin
      act_q <= in_action;
      key_q <= in_key;
      id_q  <= in_owner_id;
    end
    if (cmd.op == folc_pkg::OP_DECIDE) ins_slot <= ins_c;
    if (rd_scan) begin
      if (mv && key_rd == key_q && !hit_f) begin
        slot     <= rd_idx;
        hit_rank <= mk;
        hit_id   <= id_rd;
      end
      if (mv && CNT_W'(mk) == count_m1) old_slot <= rd_idx;
      if (!mv && !free_f) free_slot <= rd_idx;
    end
    if (cmd.op == folc_pkg::OP_FINISH) begin
      out_hit         <= hit_f;
      out_found_id    <= (act_q == folc_pkg::ACT_LOOKUP && hit_f) ? hit_id
                                                                 : folc_pkg::NOT_FOUND_ID;
      out_entry_count <= count_next;
      out_evicted     <= ev;
    end
  end

  assign stat.idx_last   = (idx == IDX_LAST);
  assign stat.need_sweep = hit_f || (act_q == folc_pkg::ACT_ADD);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

@@ design/flow_owner_lru_cache.sv @@
// Top level: flow owner LRU cache with APB register port.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | valid/ready        | action, five-tuple key, ip_version, owner_id
//  rsp     | out | valid/ready        | hit, found_id, entry_count, evicted
//  apb     | in  | psel/penable/pready| max_entries at byte address 0
//
//  Cycles: about 2*CAPACITY+4 per item (132 at 64 entries); a lookup miss
//    skips the rank sweep, about CAPACITY+4. Set by the single-port entry
//    memory: one scan pass for match, oldest entry and free slot, then one
//    read-modify-write pass over the rank memory.
//  Reset: after rst the rank/valid memory is swept clear, CAPACITY cycles,
//    during which no item is taken; register writes are taken throughout.
//  Stalls: the result sits in an output register; the next item is taken
//    while it waits, and only its hand-off holds if rsp is still stalled.
module flow_owner_lru_cache #(
  parameter int CAPACITY = folc_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  flow_req_if.sink                            req,
  flow_rsp_if.source                          rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [folc_pkg::PADDR_W-1:0]        paddr,
  input  logic [folc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [folc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  folc_pkg::folc_cmd_t  cmd;
  folc_pkg::folc_stat_t stat;

  logic [folc_pkg::MAX_ENTRIES_W-1:0] max_entries;
  logic [folc_pkg::KEY_W-1:0]         key;
  logic [CNT_W-1:0]                   entry_count;

  // register port: word select is paddr[2], low bits ignored
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= folc_pkg::MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && paddr[2] == folc_pkg::REG_MAX_ENTRIES) begin
      max_entries <= pwdata[folc_pkg::MAX_ENTRIES_W-1:0];
    end
  end

  assign prdata = (paddr[2] == folc_pkg::REG_MAX_ENTRIES)
                ? folc_pkg::CFG_DATA_W'(max_entries) : '0;

  // full match key: every field of the tuple takes part
  assign key = {req.src_addr_high, req.src_addr_low, req.dst_addr_high, req.dst_addr_low,
                req.src_port, req.dst_port, req.protocol, req.ip_version};

  folc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  folc_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (req.action),
    .in_key          (key),
    .in_owner_id     (req.owner_id),
    .max_entries     (max_entries),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_hit         (rsp.hit),
    .out_found_id    (rsp.found_id),
    .out_entry_count (entry_count),
    .out_evicted     (rsp.evicted)
  );

  assign rsp.entry_count = entry_count;

endmodule

@@ design/folc_checker.sv @@
// Checker: port-level assertions on the result channel, bound to the top level.
module folc_checker #(
  parameter int CAPACITY = folc_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic                             rsp_hit,
  input logic signed [folc_pkg::ID_W-1:0] rsp_found_id,
  input logic [CNT_W-1:0]                 rsp_entry_count,
  input logic                             rsp_evicted
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_found_id)
      && $stable(rsp_entry_count) && $stable(rsp_evicted))
    else $error("result changed while stalled");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_miss_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_found_id == folc_pkg::NOT_FOUND_ID)
    else $error("miss returned an id");

  a_evict_add: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_evicted |-> rsp_found_id == folc_pkg::NOT_FOUND_ID)
    else $error("eviction reported on a lookup");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid straight after reset");

endmodule

bind flow_owner_lru_cache folc_checker #(
  .CAPACITY (CAPACITY)
) u_folc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_found_id    (rsp.found_id),
  .rsp_entry_count (rsp.entry_count),
  .rsp_evicted     (rsp.evicted)
);

@@ sim/tb.sv @@
// Testbench for the flow owner LRU cache: directed and random traffic against an LRU predictor.
module tb;

  localparam int CAP = 64;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [folc_pkg::PADDR_W-1:0] paddr;
  logic [folc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [folc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  flow_req_if req ();
  flow_rsp_if rsp ();

  flow_owner_lru_cache dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // one flow key plus action and owner id, as sent on req
  typedef struct packed {
    logic                             action;
    logic [folc_pkg::ADDR_W-1:0]      sh;
    logic [folc_pkg::ADDR_W-1:0]      sl;
    logic [folc_pkg::ADDR_W-1:0]      dh;
    logic [folc_pkg::ADDR_W-1:0]      dl;
    logic [folc_pkg::PORT_W-1:0]      sp;
    logic [folc_pkg::PORT_W-1:0]      dp;
    logic [folc_pkg::PROTO_W-1:0]     proto;
    logic                             ver;
    logic signed [folc_pkg::ID_W-1:0] id;
  } flow_item_t;

  typedef struct packed {
    logic                             hit;
    logic signed [folc_pkg::ID_W-1:0] found_id;
    logic [6:0]                       entry_count;
    logic                             evicted;
  } owner_result_t;

  // predictor state: the cached flows, their ranks (0 newest) and the limit
  logic [folc_pkg::KEY_W-1:0] flow_key [CAP];
  logic [folc_pkg::ID_W-1:0]  flow_owner [CAP];
  logic                       flow_valid [CAP];
  int unsigned                flow_rank [CAP];
  int unsigned                flows_held;
  logic [6:0]                 limit_reg;

  owner_result_t expected_results [$];
  int  mismatches;
  int  results_seen;
  bit  failed;
  bit  hold_rsp;        // long receiver hold-off for the back-pressure test

  // pool of keys reused by random traffic so that hits and updates happen
  flow_item_t key_pool [48];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [folc_pkg::KEY_W-1:0] key_of(input flow_item_t it);
    return {it.sh, it.sl, it.dh, it.dl, it.sp, it.dp, it.proto, it.ver};
  endfunction

  function automatic int unsigned limit_now();
    if (limit_reg == 0) return 1;
    if (limit_reg > CAP) return CAP;
    return 32'(limit_reg);
  endfunction

  function automatic void make_newest(input int s);
    for (int i = 0; i < CAP; i++)
      if (flow_valid[i] && flow_rank[i] < flow_rank[s]) flow_rank[i]++;
    flow_rank[s] = 0;
  endfunction

  function automatic void drop_oldest();
    for (int i = 0; i < CAP; i++)
      if (flow_valid[i] && flow_rank[i] == flows_held - 1) begin
        flow_valid[i] = 1'b0;
        flow_rank[i] = 0;
        flows_held--;
        return;
      end
  endfunction

  // works out the result of one item and updates the predicted cache
  function automatic owner_result_t predict_owner(input flow_item_t it);
    owner_result_t r;
    logic [folc_pkg::KEY_W-1:0] k;
    int slot;
    k = key_of(it);
    slot = -1;
    r = '0;
    r.found_id = folc_pkg::NOT_FOUND_ID;
    for (int i = 0; i < CAP; i++)
      if (slot < 0 && flow_valid[i] && flow_key[i] == k) slot = i;
    r.hit = (slot >= 0);
    if (it.action == folc_pkg::ACT_LOOKUP) begin
      if (slot >= 0) begin
        r.found_id = flow_owner[slot];
        make_newest(slot);
      end
    end else if (slot >= 0) begin
      flow_owner[slot] = it.id;
      make_newest(slot);
      if (flows_held > limit_now()) begin
        drop_oldest();
        r.evicted = 1'b1;
      end
    end else begin
      if (flows_held + 1 > limit_now() && flows_held > 0) begin
        drop_oldest();
        r.evicted = 1'b1;
      end
      for (int i = 0; i < CAP; i++)
        if (slot < 0 && !flow_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < CAP; i++)
          if (flow_valid[i]) flow_rank[i]++;
        flow_key[slot] = k;
        flow_owner[slot] = it.id;
        flow_valid[slot] = 1'b1;
        flow_rank[slot] = 0;
        flows_held++;
      end
    end
    r.entry_count = flows_held[6:0];
    return r;
  endfunction

  // burst/gap pacing on the sender side
  int burst_left;

  task automatic send_item(input flow_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 150)) @(posedge clk);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.action <= it.action;
    req.src_addr_high <= it.sh;
    req.src_addr_low <= it.sl;
    req.dst_addr_high <= it.dh;
    req.dst_addr_low <= it.dl;
    req.src_port <= it.sp;
    req.dst_port <= it.dp;
    req.protocol <= it.proto;
    req.ip_version <= it.ver;
    req.owner_id <= it.id;
    do @(posedge clk); while (!req.ready);
    expected_results.push_back(predict_owner(it));
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] value);
    // drain all results, then wait before the register write
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * CAP + 20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= folc_pkg::PADDR_W'(folc_pkg::REG_MAX_ENTRIES) << 2;
    pwdata <= folc_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = value;
  endtask

  function automatic flow_item_t random_flow();
    flow_item_t it;
    it.action = 1'($urandom_range(0, 1));
    it.ver = 1'($urandom_range(0, 1));
    it.sh = it.ver ? {$urandom, $urandom} : '0;
    it.dh = it.ver ? {$urandom, $urandom} : '0;
    it.sl = {$urandom, $urandom};
    it.dl = {$urandom, $urandom};
    it.sp = folc_pkg::PORT_W'($urandom);
    it.dp = folc_pkg::PORT_W'($urandom);
    it.proto = folc_pkg::PROTO_W'($urandom);
    it.id = ($urandom_range(0, 9) == 0) ? -32'sd1
          : $signed(folc_pkg::ID_W'($urandom_range(0, 32'h7fffffff)));
    return it;
  endfunction

  // draws from the key pool; some keys differ from a pool key in one field only
  function automatic flow_item_t pool_flow(input int spread);
    flow_item_t it;
    it = key_pool[$urandom_range(0, spread - 1)];
    it.action = $urandom_range(0, 2) == 0 ? folc_pkg::ACT_ADD : folc_pkg::ACT_LOOKUP;
    it.id = $signed(folc_pkg::ID_W'($urandom_range(0, 32'h7fffffff)));
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 5))
        0: it.sl[$urandom_range(0, 63)] ^= 1'b1;
        1: it.dh[$urandom_range(0, 63)] ^= 1'b1;
        2: it.sp[$urandom_range(0, 15)] ^= 1'b1;
        3: it.proto[$urandom_range(0, 7)] ^= 1'b1;
        4: it.ver ^= 1'b1;
        default: it.sh[$urandom_range(0, 63)] ^= 1'b1;
      endcase
    end
    return it;
  endfunction

  // receiver: own stall pattern, plus the long hold-off when asked
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 7) < 5) || ($time / 20000) % 3 == 0;
    end
  end

  // checker: compare each accepted result with the oldest expectation
  initial begin
    owner_result_t exp_r;
    owner_result_t got;
    mismatches = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = {rsp.hit, rsp.found_id, rsp.entry_count, rsp.evicted};
        results_seen++;
        if (expected_results.size() == 0) begin
          failed = 1'b1;
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            failed = 1'b1;
            if (mismatches < 10) $display("mismatch: expected %p, got %p", exp_r, got);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    flow_item_t a;
    flow_item_t b;
    a = '0;
    a.action = folc_pkg::ACT_LOOKUP;
    send_item(a);                        // lookup in an empty cache
    a.action = folc_pkg::ACT_ADD; a.id = -1;
    send_item(a);                        // all-zero IPv4 key, id of -1
    a.action = folc_pkg::ACT_LOOKUP;
    send_item(a);
    b = '1;
    b.action = folc_pkg::ACT_ADD; b.id = 32'sh7fffffff;
    send_item(b);                        // all-ones IPv6 key, largest id
    b.action = folc_pkg::ACT_LOOKUP;
    send_item(b);
    b.action = folc_pkg::ACT_ADD; b.id = 0;
    send_item(b);                        // add of a stored key rewrites its id
    b.action = folc_pkg::ACT_LOOKUP;
    send_item(b);
    b.ver = 1'b0;
    send_item(b);                        // keys differing only in version miss
    b.ver = 1'b1; b.proto = 8'hfe;
    send_item(b);
    b.proto = 8'hff; b.dp = 16'h7fff;
    send_item(b);
  endtask

  task automatic test_limits();
    flow_item_t it;
    // limit one: every new add evicts
    write_limit(7'd1);
    for (int i = 0; i < 6; i++) begin
      it = key_pool[i]; it.action = folc_pkg::ACT_ADD; send_item(it);
      it.action = folc_pkg::ACT_LOOKUP; send_item(it);
    end
    // zero acts as one; a re-add of a stored key evicts only while the count exceeds the limit
    write_limit(7'd0);
    it = key_pool[5]; it.action = folc_pkg::ACT_ADD; send_item(it);
    it = key_pool[0]; it.action = folc_pkg::ACT_ADD; send_item(it);
    // above capacity acts as capacity: fill past 64
    write_limit(7'd127);
    for (int i = 0; i < 70; i++) begin
      it = random_flow(); it.action = folc_pkg::ACT_ADD; send_item(it);
    end
    // limit lowered below the count: each add evicts one; the count falls only on a re-add of a stored key
    write_limit(7'd3);
    it = key_pool[1]; it.action = folc_pkg::ACT_LOOKUP; send_item(it);
    for (int i = 0; i < 8; i++) begin
      it = key_pool[i]; it.action = folc_pkg::ACT_ADD; send_item(it);
    end
  endtask

  task automatic test_random(input int n, input int spread);
    flow_item_t it;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) it = pool_flow(spread);
      else it = random_flow();
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    flow_item_t it;
    hold_rsp = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        it = pool_flow(8); send_item(it);
      end
    join
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req.valid = 1'b0; req.action = folc_pkg::ACT_LOOKUP;
    req.src_addr_high = '0; req.src_addr_low = '0;
    req.dst_addr_high = '0; req.dst_addr_low = '0;
    req.src_port = '0; req.dst_port = '0; req.protocol = '0;
    req.ip_version = 1'b0; req.owner_id = '0;
    failed = 1'b0; hold_rsp = 1'b0; burst_left = 0;
    flows_held = 0;
    limit_reg = folc_pkg::MAX_ENTRIES_RST;
    for (int i = 0; i < CAP; i++) begin
      flow_valid[i] = 1'b0; flow_rank[i] = 0; flow_key[i] = '0; flow_owner[i] = '0;
    end
    for (int i = 0; i < 48; i++) key_pool[i] = random_flow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_limits();
    write_limit(7'd64);
    test_random(300, 48);
    write_limit(7'd8);
    test_random(300, 16);
    write_limit(7'd30);
    test_random(300, 48);
    test_backpressure();
    write_limit(7'd2);
    test_random(150, 6);
    write_limit(7'd64);
    test_random(100, 48);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * CAP + 20) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/folc_pkg.sv
design/folc_if.sv
design/folc_ctrl.sv
design/folc_dp.sv
design/flow_owner_lru_cache.sv
design/folc_checker.sv
sim/tb.sv
